### hdl/mbts_pkg.sv
// Shared types and constants for the media box type scanner.
// No dependencies; mbts_core, mbts_skid and the top level import this package.
package mbts_pkg;

  localparam logic [31:0] TARGET_RESET = 32'h6D6F6F66;  // "moof"

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_LARGE  = 2'd1,
    PH_SKIP   = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    CAUSE_MATCH = 2'd0,
    CAUSE_END   = 2'd1,
    CAUSE_ZERO  = 2'd2,
    CAUSE_SMALL = 2'd3
  } cause_t;

  typedef struct packed {
    logic   found;
    cause_t stop_cause;
  } result_t;

endpackage

### hdl/mbts_if.sv
// Valid/ready channel interfaces for the scanner's byte input and result output.
// Depends on nothing; payload widths are fixed by the byte stream format.
interface mbts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface mbts_out_if;
  logic       valid;
  logic       ready;
  logic       found;
  logic [1:0] stop_cause;

  modport source (output valid, output found, output stop_cause, input ready);
  modport sink   (input valid, input found, input stop_cause, output ready);
endinterface

### hdl/media_box_type_scanner_top.sv
// Top level of the media box type scanner.
// Depends on mbts_pkg, mbts_if, mbts_core and mbts_skid.
//
// Usage:
//   in_ch carries one buffer byte per transaction (data_byte, last_byte set on
//   the buffer's final byte). out_ch carries one result per buffer: found and
//   stop_cause. cfg_we/cfg_wdata load the 32-bit box type to look for; write it
//   only while no buffer is in flight.
//   Throughput is one byte per cycle while in_ch.ready is high; the header/skip
//   state updates on each byte; a 64-bit decrement or compare is the longest path.
//   The result of the deciding byte (or the last byte) is registered in the
//   result register, or first in the skid stage when the receiver stalls.
//   When the receiver stalls, one further result is held in a skid stage; only
//   once that stage is occupied does in_ch.ready drop. in_ch.ready is a
//   register output and does not depend on out_ch.ready.
//   Synchronous reset (rst_n low) clears the scan state, empties both result
//   stages and restores the target type to "moof".
module media_box_type_scanner_top (
  input  logic        clk,
  input  logic        rst_n,
  mbts_in_if.sink     in_ch,
  mbts_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);
  import mbts_pkg::*;

  logic [31:0] target_r;
  logic        step;
  logic        push_ready;
  logic        res_valid;
  result_t     res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= TARGET_RESET;
    end else if (cfg_we) begin
      target_r <= cfg_wdata;
    end
  end

  assign in_ch.ready = push_ready;
  assign step        = in_ch.valid && push_ready;

  mbts_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .data_byte   (in_ch.data_byte),
    .last_byte   (in_ch.last_byte),
    .target_type (target_r),
    .res_valid   (res_valid),
    .res         (res)
  );

  mbts_skid u_skid (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (res_valid),
    .push_data  (res),
    .push_ready (push_ready),
    .out_ch     (out_ch)
  );

endmodule

### hdl/mbts_core.sv
// Box header walker: per-byte state update and decision logic.
// Depends on mbts_pkg.
module mbts_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  input  logic [31:0]         target_type,
  output logic                res_valid,
  output mbts_pkg::result_t   res
);
  import mbts_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [2:0]  hdr_cnt_r, hdr_cnt_nxt;
  logic [63:0] box_size_r, box_size_nxt;
  logic [31:0] type_r, type_nxt;
  logic [63:0] skip_r, skip_nxt;

  logic        decided;
  logic        found;
  cause_t      cause;
  logic [63:0] skip_amt;
  logic        start_skip;

  always_comb begin
    phase_nxt    = phase_r;
    hdr_cnt_nxt  = hdr_cnt_r;
    box_size_nxt = box_size_r;
    type_nxt     = type_r;
    skip_nxt     = skip_r;
    decided      = 1'b0;
    found        = 1'b0;
    cause        = CAUSE_END;
    skip_amt     = '0;
    start_skip   = 1'b0;

    unique case (phase_r)
      PH_HEADER: begin
        if (!hdr_cnt_r[2]) begin
          box_size_nxt = {32'd0, box_size_r[23:0], data_byte};
        end else begin
          type_nxt = {type_r[23:0], data_byte};
        end
        hdr_cnt_nxt = hdr_cnt_r + 3'd1;
        if (hdr_cnt_r == 3'd7) begin
          // type is checked before the size is validated
          if (type_nxt == target_type) begin
            decided = 1'b1;
            found   = 1'b1;
            cause   = CAUSE_MATCH;
          end else if (box_size_r == 64'd1) begin
            phase_nxt = PH_LARGE;
          end else if (box_size_r == 64'd0) begin
            decided = 1'b1;
            cause   = CAUSE_ZERO;
          end else if (box_size_r < 64'd8) begin
            decided = 1'b1;
            cause   = CAUSE_SMALL;
          end else begin
            start_skip = 1'b1;
            skip_amt   = box_size_r - 64'd8;
          end
        end
      end
      PH_LARGE: begin
        // eight shifts overwrite the whole register, no clear needed
        box_size_nxt = {box_size_r[55:0], data_byte};
        hdr_cnt_nxt  = hdr_cnt_r + 3'd1;
        if (hdr_cnt_r == 3'd7) begin
          if (box_size_nxt < 64'd16) begin
            decided = 1'b1;
            cause   = CAUSE_SMALL;
          end else begin
            start_skip = 1'b1;
            skip_amt   = box_size_nxt - 64'd16;
          end
        end
      end
      PH_SKIP: begin
        // never entered with zero left
        skip_nxt = skip_r - 64'd1;
        if (skip_r == 64'd1) begin
          phase_nxt = PH_HEADER;
        end
      end
      PH_DONE: begin
      end
      default: begin
      end
    endcase

    if (start_skip) begin
      skip_nxt  = skip_amt;
      phase_nxt = (skip_amt != 64'd0) ? PH_SKIP : PH_HEADER;
    end

    if (decided) begin
      phase_nxt = PH_DONE;
    end

    res_valid      = step && (decided || (last_byte && (phase_r != PH_DONE)));
    res.found      = decided && found;
    res.stop_cause = decided ? cause : CAUSE_END;

    if (last_byte) begin
      phase_nxt    = PH_HEADER;
      hdr_cnt_nxt  = '0;
      box_size_nxt = '0;
      type_nxt     = '0;
      skip_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      hdr_cnt_r  <= '0;
      box_size_r <= '0;
      type_r     <= '0;
      skip_r     <= '0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      hdr_cnt_r  <= hdr_cnt_nxt;
      box_size_r <= box_size_nxt;
      type_r     <= type_nxt;
      skip_r     <= skip_nxt;
    end
  end

endmodule

### hdl/mbts_skid.sv
// Result register with a skid stage, so input ready never waits on out ready.
// Depends on mbts_pkg and mbts_if.
module mbts_skid (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  input  mbts_pkg::result_t push_data,
  output logic              push_ready,
  mbts_out_if.source        out_ch
);
  import mbts_pkg::*;

  logic    out_valid_r, out_valid_nxt;
  result_t out_data_r, out_data_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t skid_data_r, skid_data_nxt;

  assign push_ready = !skid_valid_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || out_ch.ready) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = push_valid;
        out_data_nxt  = push_data;
      end
    end else if (push_valid) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.found      = out_data_r.found;
  assign out_ch.stop_cause = out_data_r.stop_cause;

endmodule
